### hdl/base64_line_wrapped_encoder_core_macros.svh
// ============================================================================
// Base64 line-wrapped encoder assertion macros
// Shared concurrent assertion shorthands, clocked on clk and disabled in reset.
// ============================================================================
`ifndef BASE64_LINE_WRAPPED_ENCODER_CORE_MACROS_SVH
`define BASE64_LINE_WRAPPED_ENCODER_CORE_MACROS_SVH

// Same-cycle implication.
`define B64LE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define B64LE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/b64le_pkg.sv
// ============================================================================
// Base64 line-wrapped encoder package
// Types, constants and the alphabet lookup shared by the encoder modules.
// ============================================================================
package b64le_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [6:0] LINE_LIMIT = 7'd72;
    localparam logic [6:0] GROUP_CHARS = 7'd4;

    localparam logic [7:0] CHR_CR = 8'h0d;
    localparam logic [7:0] CHR_LF = 8'h0a;
    localparam logic [7:0] CHR_PAD = 8'h3d;
    localparam logic [7:0] CHR_PLUS = 8'h2b;
    localparam logic [7:0] CHR_SLASH = 8'h2f;
    localparam logic [5:0] SEXTET_SLASH = 6'h3f;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_FULL = 2'd0;
    localparam kind_t KIND_PAD1 = 2'd1;
    localparam kind_t KIND_PAD2 = 2'd2;

    typedef struct packed {
        logic        crlf;
        kind_t       kind;
        logic [23:0] bits;
    } job_t;

    function automatic logic [7:0] alphabet(input logic [5:0] v);
        logic [7:0] ch;
        if (v < 6'd26)
        begin
            ch = 8'h41 + {2'b00, v};
        end
        else if (v < 6'd52)
        begin
            ch = 8'h61 + {2'b00, v - 6'd26};
        end
        else if (v < 6'd62)
        begin
            ch = 8'h30 + {2'b00, v - 6'd52};
        end
        else if (v == SEXTET_SLASH)
        begin
            ch = CHR_SLASH;
        end
        else
        begin
            ch = CHR_PLUS;
        end
        return ch;
    endfunction

endpackage

### hdl/b64le_front.sv
// ============================================================================
// Base64 encoder front end
// Accepts bytes and flushes, tracks group and line state, and queues jobs.
// ============================================================================
module b64le_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic             opcode,
    input  logic [7:0]       data_byte,
    input  logic             queue_full,
    output logic             push,
    output b64le_pkg::job_t  job
);

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [15:0] held_reg;
    logic [15:0] held_next;
    logic [6:0]  len_reg;
    logic [6:0]  len_next;
    logic        accept;
    logic        wrap;

    assign item_stall = queue_full;
    assign accept = item_valid && !queue_full;
    assign wrap = len_reg > b64le_pkg::LINE_LIMIT;

    always_comb
    begin
        phase_next = phase_reg;
        held_next = held_reg;
        len_next = len_reg;
        push = 1'b0;
        job.crlf = wrap;
        job.kind = b64le_pkg::KIND_FULL;
        job.bits = {held_reg, data_byte};
        if (accept)
        begin
            if (opcode == b64le_pkg::OP_DATA)
            begin
                unique case (phase_reg)
                    2'd0:
                    begin
                        held_next = {data_byte, 8'h00};
                        phase_next = 2'd1;
                    end
                    2'd1:
                    begin
                        held_next = {held_reg[15:8], data_byte};
                        phase_next = 2'd2;
                    end
                    default:
                    begin
                        phase_next = 2'd0;
                        push = 1'b1;
                        len_next = (wrap ? 7'd0 : len_reg) + b64le_pkg::GROUP_CHARS;
                    end
                endcase
            end
            else
            begin
                phase_next = 2'd0;
                held_next = 16'h0000;
                len_next = 7'd0;
                push = phase_reg != 2'd0;
                if (phase_reg == 2'd1)
                begin
                    job.kind = b64le_pkg::KIND_PAD2;
                    job.bits = {held_reg[15:8], 16'h0000};
                end
                else
                begin
                    job.kind = b64le_pkg::KIND_PAD1;
                    job.bits = {held_reg, 8'h00};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            held_reg <= 16'h0000;
            len_reg <= 7'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg <= held_next;
            len_reg <= len_next;
        end
    end

endmodule

### hdl/b64le_queue.sv
// ============================================================================
// Base64 encoder job queue
// Short register FIFO that decouples the front end from the character sequencer.
// ============================================================================
`include "base64_line_wrapped_encoder_core_macros.svh"

module b64le_queue
#(
    parameter int unsigned DEPTH = b64le_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  b64le_pkg::job_t  push_job,
    input  logic             pop,
    output b64le_pkg::job_t  pop_job,
    output logic             full,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    b64le_pkg::job_t  store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign pop_job = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    `B64LE_ASSERT_SAME(a_pop_not_empty, pop, !empty, "queue popped while empty")
    `B64LE_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count overflow")

endmodule

### hdl/b64le_back.sv
// ============================================================================
// Base64 encoder character sequencer
// Turns queued jobs into line breaks, alphabet characters and padding.
// ============================================================================
`include "base64_line_wrapped_encoder_core_macros.svh"

module b64le_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             queue_empty,
    input  b64le_pkg::job_t  queue_job,
    output logic             pop,
    output logic             char_valid,
    input  logic             char_stall,
    output logic [7:0]       out_char,
    output logic             last
);

    localparam logic [2:0] STEP_CR = 3'd0;
    localparam logic [2:0] STEP_LF = 3'd1;
    localparam logic [2:0] STEP_S0 = 3'd2;
    localparam logic [2:0] STEP_S1 = 3'd3;
    localparam logic [2:0] STEP_S2 = 3'd4;
    localparam logic [2:0] STEP_S3 = 3'd5;

    b64le_pkg::job_t cur_reg;
    b64le_pkg::job_t cur_next;
    logic            cur_valid_reg;
    logic            cur_valid_next;
    logic [2:0]      step_reg;
    logic [2:0]      step_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [7:0]      out_char_reg;
    logic [7:0]      out_char_next;
    logic            last_reg;
    logic            last_next;
    logic            advance;
    logic            finish;
    logic [7:0]      ch;

    assign char_valid = out_valid_reg;
    assign out_char = out_char_reg;
    assign last = last_reg;

    assign advance = cur_valid_reg && (!out_valid_reg || !char_stall);
    assign finish = advance && (step_reg == STEP_S3);
    assign pop = !queue_empty && (!cur_valid_reg || finish);

    always_comb
    begin
        unique case (step_reg)
            STEP_CR: ch = b64le_pkg::CHR_CR;
            STEP_LF: ch = b64le_pkg::CHR_LF;
            STEP_S0: ch = b64le_pkg::alphabet(cur_reg.bits[23:18]);
            STEP_S1: ch = b64le_pkg::alphabet(cur_reg.bits[17:12]);
            STEP_S2: ch = (cur_reg.kind == b64le_pkg::KIND_PAD2) ? b64le_pkg::CHR_PAD
                        : b64le_pkg::alphabet(cur_reg.bits[11:6]);
            STEP_S3: ch = (cur_reg.kind == b64le_pkg::KIND_FULL)
                        ? b64le_pkg::alphabet(cur_reg.bits[5:0]) : b64le_pkg::CHR_PAD;
            default: ch = b64le_pkg::CHR_PAD;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && char_stall;
        out_char_next = out_char_reg;
        last_next = last_reg;
        cur_next = cur_reg;
        cur_valid_next = cur_valid_reg;
        step_next = step_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_char_next = ch;
            last_next = step_reg == STEP_S3;
            step_next = step_reg + 3'd1;
        end
        if (pop)
        begin
            cur_next = queue_job;
            cur_valid_next = 1'b1;
            step_next = queue_job.crlf ? STEP_CR : STEP_S0;
        end
        else if (finish)
        begin
            cur_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_char_reg <= out_char_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg <= STEP_CR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `B64LE_ASSERT_NEXT(a_cr_then_lf, out_valid_reg && out_char_reg == b64le_pkg::CHR_CR, out_valid_reg && out_char_reg == b64le_pkg::CHR_LF || out_char_reg == b64le_pkg::CHR_CR, "CR not followed by LF")
    `B64LE_ASSERT_SAME(a_last_not_break, out_valid_reg && last_reg, out_char_reg != b64le_pkg::CHR_CR && out_char_reg != b64le_pkg::CHR_LF, "last flagged on a line break")
    `B64LE_ASSERT_SAME(a_step_range, cur_valid_reg, step_reg <= STEP_S3, "sequencer step out of range")

endmodule

### hdl/base64_line_wrapped_encoder_core.sv
// ============================================================================
// Base64 line-wrapped encoder core
// MIME Base64 encoder with CR LF line wrapping and end-of-stream padding.
// ============================================================================
// The encoder takes one byte or flush per cycle while its job queue has room
// and, while char_stall is low, sends one character per cycle on the output
// side; a completed group of three bytes yields four characters, or six when
// a CR LF line break comes first, a flush of a partial group yields four or
// six, and a flush with no held bytes yields none. The output register and
// its single character per cycle set the sustained rate. A character waiting
// at a stalled output does not stop the input side until the queue holds
// QUEUE_DEPTH groups beside the one being sent. The last flag marks the final
// character of each encoded group.
module base64_line_wrapped_encoder_core
#(
    parameter int unsigned QUEUE_DEPTH = b64le_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic       opcode,
    input  logic [7:0] data_byte,
    output logic       char_valid,
    input  logic       char_stall,
    output logic [7:0] out_char,
    output logic       last
);

    b64le_pkg::job_t push_job;
    b64le_pkg::job_t pop_job;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_empty;

    b64le_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .opcode     (opcode),
        .data_byte  (data_byte),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    b64le_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    b64le_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_job   (pop_job),
        .pop         (pop),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .out_char    (out_char),
        .last        (last)
    );

endmodule

### tb/base64_line_wrapped_encoder_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Base64 line-wrapped encoder core testbench
// Sends data bytes and flushes through the encoder, predicts every character
// and its last flag, and checks each output transfer against the prediction
// under random idling, a long receiver hold-off and a drain pause.
// ============================================================================
module base64_line_wrapped_encoder_core_test;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    logic       opcode = b64le_pkg::OP_DATA;
    logic [7:0] data_byte = 8'h00;
    logic       char_valid;
    logic       char_stall = 1'b0;
    logic [7:0] out_char;
    logic       last;

    enc_char_t  expected_chars[$];
    int         error_count = 0;

    logic [1:0] model_phase = 2'd0;
    logic [15:0] model_held = 16'h0000;
    logic [6:0] model_line_len = 7'd0;

    bit         sender_idle_on = 1'b0;
    bit         receiver_idle_on = 1'b0;
    int         hold_requests = 0;
    int         hold_seen = 0;
    int         hold_left = 0;

    base64_line_wrapped_encoder_core u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .opcode     (opcode),
        .data_byte  (data_byte),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .out_char   (out_char),
        .last       (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("[base64_line_wrapped_encoder_core] ERROR");
        $finish;
    end

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        string charset;
        charset = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        return charset[v];
    endfunction

    function automatic void encode_item(input logic op, input logic [7:0] b);
        logic [23:0] grp;
        logic [1:0]  ph;
        logic [6:0]  len;
        logic [7:0]  chars[$];
        enc_char_t   e;
        ph = model_phase;
        len = model_line_len;
        if (op == b64le_pkg::OP_DATA)
        begin
            if (ph == 2'd0)
            begin
                model_held = {b, 8'h00};
                model_phase = 2'd1;
                return;
            end
            if (ph == 2'd1)
            begin
                model_held[7:0] = b;
                model_phase = 2'd2;
                return;
            end
            model_phase = 2'd0;
            if (len > b64le_pkg::LINE_LIMIT)
            begin
                chars.push_back(b64le_pkg::CHR_CR);
                chars.push_back(b64le_pkg::CHR_LF);
                len = 7'd0;
            end
            model_line_len = len + b64le_pkg::GROUP_CHARS;
            grp = {model_held, b};
            chars.push_back(b64_char(grp[23:18]));
            chars.push_back(b64_char(grp[17:12]));
            chars.push_back(b64_char(grp[11:6]));
            chars.push_back(b64_char(grp[5:0]));
        end
        else
        begin
            grp = {model_held, 8'h00};
            if (ph == 2'd1)
            begin
                grp[15:0] = 16'h0000;
            end
            model_phase = 2'd0;
            model_held = 16'h0000;
            model_line_len = 7'd0;
            if (ph == 2'd0)
            begin
                return;
            end
            if (len > b64le_pkg::LINE_LIMIT)
            begin
                chars.push_back(b64le_pkg::CHR_CR);
                chars.push_back(b64le_pkg::CHR_LF);
            end
            chars.push_back(b64_char(grp[23:18]));
            chars.push_back(b64_char(grp[17:12]));
            if (ph == 2'd1)
            begin
                chars.push_back(b64le_pkg::CHR_PAD);
            end
            else
            begin
                chars.push_back(b64_char(grp[11:6]));
            end
            chars.push_back(b64le_pkg::CHR_PAD);
        end
        foreach (chars[i])
        begin
            e.ch = chars[i];
            e.last = (i == chars.size() - 1);
            expected_chars.push_back(e);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        enc_char_t e;
        if (rst_n && char_valid && !char_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch("unexpected char", int'(out_char), 0);
            end
            else
            begin
                e = expected_chars.pop_front();
                if (out_char !== e.ch)
                begin
                    report_mismatch("out_char", int'(out_char), int'(e.ch));
                end
                if (last !== e.last)
                begin
                    report_mismatch("last", int'(last), int'(e.last));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            char_stall = 1'b1;
            hold_left--;
        end
        else
        begin
            char_stall = receiver_idle_on && ($urandom_range(99) < 27);
        end
    end

    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        gap = 0;
        if (sender_idle_on)
        begin
            while ($urandom_range(99) < 27)
            begin
                gap++;
            end
        end
        repeat (gap)
        begin
            @(negedge clk);
            item_valid = 1'b0;
        end
        @(negedge clk);
        item_valid = 1'b1;
        opcode = op;
        data_byte = b;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        encode_item(op, b);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid = 1'b0;
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic send_groups(input int count);
        repeat (3 * count)
        begin
            send_item(b64le_pkg::OP_DATA, 8'($urandom));
        end
    endtask

    task automatic test_directed();
        send_item(b64le_pkg::OP_DATA, 8'h00);
        send_item(b64le_pkg::OP_DATA, 8'h00);
        send_item(b64le_pkg::OP_DATA, 8'h00);
        send_item(b64le_pkg::OP_DATA, 8'hff);
        send_item(b64le_pkg::OP_DATA, 8'hff);
        send_item(b64le_pkg::OP_DATA, 8'hff);
        send_item(b64le_pkg::OP_DATA, 8'hfb);
        send_item(b64le_pkg::OP_DATA, 8'hef);
        send_item(b64le_pkg::OP_DATA, 8'hbe);
        send_item(b64le_pkg::OP_FLUSH, 8'h00);
        send_item(b64le_pkg::OP_DATA, 8'h4d);
        send_item(b64le_pkg::OP_FLUSH, 8'hff);
        send_item(b64le_pkg::OP_DATA, 8'h4d);
        send_item(b64le_pkg::OP_DATA, 8'h61);
        send_item(b64le_pkg::OP_FLUSH, 8'ha5);
        send_item(b64le_pkg::OP_DATA, 8'h80);
        send_item(b64le_pkg::OP_DATA, 8'h01);
        send_item(b64le_pkg::OP_DATA, 8'h7f);
        send_item(b64le_pkg::OP_FLUSH, 8'h5a);
        send_item(b64le_pkg::OP_FLUSH, 8'hff);
        wait_drained();
    endtask

    task automatic test_line_wrap();
        send_groups(19);
        send_item(b64le_pkg::OP_DATA, 8'($urandom));
        send_item(b64le_pkg::OP_FLUSH, 8'($urandom));
        wait_drained();
    endtask

    task automatic send_random(input int count);
        repeat (count)
        begin
            if ($urandom_range(15) == 0)
            begin
                send_item(b64le_pkg::OP_FLUSH, 8'($urandom));
            end
            else
            begin
                send_item(b64le_pkg::OP_DATA, 8'($urandom));
            end
        end
    endtask

    task automatic test_random();
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        send_random(15);
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        send_random(20);
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        send_random(15);
        wait_drained();
    endtask

    task automatic test_backpressure();
        sender_idle_on = 1'b0;
        @(negedge clk);
        hold_requests++;
        send_groups(20);
        send_item(b64le_pkg::OP_FLUSH, 8'h00);
        wait_drained();
    endtask

    task automatic test_drain_pause();
        sender_idle_on = 1'b1;
        send_random(10);
        wait_drained();
        send_random(10);
        send_item(b64le_pkg::OP_FLUSH, 8'($urandom));
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_line_wrap();
        test_random();
        test_backpressure();
        test_drain_pause();
        if (error_count == 0)
        begin
            $display("[base64_line_wrapped_encoder_core] OK");
        end
        else
        begin
            $display("[base64_line_wrapped_encoder_core] ERROR");
        end
        $finish;
    end

endmodule
